### rtl/core/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Types, constants and helpers shared by the convergence diagnostic block.
// ----------------------------------------------------------------------------
package scd_pkg;

   localparam int SCD_VARS      = 16;
   localparam int IDX_W         = 4;
   localparam int TOTAL_W       = 17;
   localparam int VSUM_W        = 48;
   localparam int SSUM_W        = 64;
   localparam int OUT_W         = 63;
   localparam int POT_W         = 32;
   localparam int HALF_W        = 16;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 17'd1024;
   localparam logic [TOTAL_W-1:0] COUNT_MAX   = 17'h1FFFF;
   localparam logic [0:0]         OP_SAMPLE   = 1'b0;
   localparam logic [0:0]         OP_QUERY    = 1'b1;

   typedef struct packed {
      logic                     opcode;
      logic [IDX_W-1:0]         var_index;
      logic signed [31:0]       sample_value;
      logic                     last_element;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         query_index;
      logic                     ready_res;
      logic [OUT_W-1:0]         between_variance;
      logic [OUT_W-1:0]         within_variance;
      logic [POT_W-1:0]         potential;
   } rsp_type;

   // Operands handed to the statistics engine for one query.
   typedef struct packed {
      logic                     start;
      logic                     calc_ok;
      logic signed [VSUM_W-1:0] s1;
      logic signed [VSUM_W-1:0] s2;
      logic [SSUM_W-1:0]        q1;
      logic [SSUM_W-1:0]        q2;
      logic [HALF_W-1:0]        n;
   } eng_req_type;

   typedef struct packed {
      logic                     done;
      logic [OUT_W-1:0]         b;
      logic [OUT_W-1:0]         w;
      logic [POT_W-1:0]         p;
   } eng_res_type;

   function automatic logic [OUT_W-1:0] sat63(input logic [127:0] x);
      logic [OUT_W-1:0] r;
      r = (x[127:OUT_W] != '0) ? {OUT_W{1'b1}} : x[OUT_W-1:0];
      return r;
   endfunction

   function automatic logic [VSUM_W-1:0] mag48(input logic signed [VSUM_W-1:0] s);
      logic [VSUM_W-1:0] r;
      r = s[VSUM_W-1] ? VSUM_W'(-s) : VSUM_W'(s);
      return r;
   endfunction

   function automatic logic [VSUM_W:0] mag49(input logic signed [VSUM_W:0] s);
      logic [VSUM_W:0] r;
      r = s[VSUM_W] ? (VSUM_W+1)'(-s) : (VSUM_W+1)'(s);
      return r;
   endfunction

endpackage

### rtl/core/scd_engine.sv
// ----------------------------------------------------------------------------
// scd_engine
// Sequenced statistics unit: a 32x32 multiply-accumulate, a one-bit-per-cycle
// 128-bit divider and a bit-serial square root compute B, W and R.
// ----------------------------------------------------------------------------
module scd_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  scd_pkg::eng_req_type eng_req,
   output scd_pkg::eng_res_type eng_res
);
   import scd_pkg::*;

   typedef enum logic [11:0] {
      E_IDLE  = 12'b000000000001,
      E_DSQ   = 12'b000000000010,
      E_BDIV  = 12'b000000000100,
      E_TSQ1  = 12'b000000001000,
      E_TSQ2  = 12'b000000010000,
      E_NUM   = 12'b000000100000,
      E_WDIV  = 12'b000001000000,
      E_RNUM  = 12'b000010000000,
      E_RDEN  = 12'b000100000000,
      E_RDIV  = 12'b001000000000,
      E_SQRT  = 12'b010000000000,
      E_DONE  = 12'b100000000000
   } est_type;

   est_type                   state_ff, state_in;

   logic signed [VSUM_W-1:0]  s1_ff, s2_ff;
   logic [SSUM_W-1:0]         q1_ff, q2_ff;
   logic [HALF_W-1:0]         n_ff;
   logic [31:0]               nn1_ff;
   logic [OUT_W-1:0]          b_ff, w_ff;
   logic [POT_W-1:0]          p_ff;
   logic [127:0]              tsq_ff;

   logic [95:0]               ma_ff;
   logic [63:0]               mb_ff;
   logic [127:0]              acc_ff, acc_in;
   logic [1:0]                mi_ff, mi_in;
   logic                      mj_ff, mj_in;

   logic [127:0]              dn_ff, dd_ff, rem_ff, quo_ff;
   logic [6:0]                cnt_ff, cnt_in;
   logic [63:0]               sq_ff;
   logic [31:0]               r_ff;

   logic [31:0]               word_a, word_b;
   logic [63:0]               pp;
   logic [1:0]                sh;
   logic [127:0]              acc_sum;
   logic                      mul_last;
   logic [127:0]              r2, rem_next, quo_next;
   logic                      ge;
   logic [31:0]               cand;
   logic [63:0]               csq;
   logic [OUT_W-1:0]          w_new;
   logic signed [VSUM_W:0]    d_in;

   always_comb begin
      unique case (mi_ff)
         2'd0:    word_a = ma_ff[31:0];
         2'd1:    word_a = ma_ff[63:32];
         default: word_a = ma_ff[95:64];
      endcase
      word_b   = mj_ff ? mb_ff[63:32] : mb_ff[31:0];
      pp       = 64'(word_a) * 64'(word_b);
      sh       = mi_ff + {1'b0, mj_ff};
      acc_sum  = acc_ff + ({64'b0, pp} << {sh, 5'b0});
      mul_last = (mi_ff == 2'd2) && mj_ff;
      r2       = {rem_ff[126:0], dn_ff[127]};
      ge       = r2 >= dd_ff;
      rem_next = ge ? r2 - dd_ff : r2;
      quo_next = {quo_ff[126:0], ge};
      cand     = r_ff | (32'd1 << cnt_ff[4:0]);
      csq      = 64'(cand) * 64'(cand);
      w_new    = sat63(quo_next);
      d_in     = {eng_req.s1[VSUM_W-1], eng_req.s1} - {eng_req.s2[VSUM_W-1], eng_req.s2};
      state_in = state_ff;
      unique case (state_ff)
         E_IDLE:  if (eng_req.start) state_in = eng_req.calc_ok ? E_DSQ : E_DONE;
         E_DSQ:   if (mul_last) state_in = E_BDIV;
         E_BDIV:  if (cnt_ff == 7'd127) state_in = E_TSQ1;
         E_TSQ1:  if (mul_last) state_in = E_TSQ2;
         E_TSQ2:  if (mul_last) state_in = E_NUM;
         E_NUM:   if (mul_last) state_in = (tsq_ff >= acc_sum) ? E_DONE : E_WDIV;
         E_WDIV:  if (cnt_ff == 7'd127) state_in = (w_new == '0) ? E_DONE : E_RNUM;
         E_RNUM:  if (mul_last) state_in = E_RDEN;
         E_RDEN:  if (mul_last) state_in = E_RDIV;
         E_RDIV:  if (cnt_ff == 7'd127) state_in = (quo_next[127:64] != '0) ? E_DONE : E_SQRT;
         E_SQRT:  if (cnt_ff[4:0] == 5'd0) state_in = E_DONE;
         E_DONE:  state_in = E_IDLE;
         default: state_in = E_IDLE;
      endcase

      // Multiply steps walk the 32-bit words, divide and root steps count
      // one bit each.
      mi_in  = mi_ff;
      mj_in  = mj_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      if (state_ff != E_IDLE && state_ff != E_DONE) begin
         if (mi_ff == 2'd2) begin
            mi_in = 2'd0;
            mj_in = 1'b1;
         end else begin
            mi_in = mi_ff + 2'd1;
         end
         cnt_in = cnt_ff + 7'd1;
      end
      unique case (state_ff)
         E_IDLE: begin
            acc_in = '0;
            mi_in  = 2'd0;
            mj_in  = 1'b0;
         end
         E_DSQ, E_NUM, E_RDEN: begin
            acc_in = acc_sum;
            if (mul_last) cnt_in = '0;
         end
         E_BDIV, E_WDIV, E_RDIV: begin
            if (cnt_ff == 7'd127) begin
               mi_in = 2'd0;
               mj_in = 1'b0;
               if (state_ff == E_BDIV) begin
                  acc_in = '0;
               end else if (state_ff == E_WDIV) begin
                  acc_in = 128'(b_ff);
               end else begin
                  cnt_in = 7'd31;
               end
            end
         end
         E_TSQ1: begin
            acc_in = acc_sum;
            if (mul_last) begin
               mi_in = 2'd0;
               mj_in = 1'b0;
            end
         end
         E_TSQ2, E_RNUM: begin
            acc_in = mul_last ? '0 : acc_sum;
            if (mul_last) begin
               mi_in = 2'd0;
               mj_in = 1'b0;
            end
         end
         E_SQRT: begin
            cnt_in = cnt_ff - 7'd1;
         end
         E_DONE: begin
            acc_in = acc_ff;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mi_ff  <= mi_in;
      mj_ff  <= mj_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      unique case (state_ff)
         E_IDLE: begin
            s1_ff  <= eng_req.s1;
            s2_ff  <= eng_req.s2;
            q1_ff  <= eng_req.q1;
            q2_ff  <= eng_req.q2;
            n_ff   <= eng_req.n;
            nn1_ff <= 32'(eng_req.n) * 32'(eng_req.n - HALF_W'(1));
            b_ff   <= '0;
            w_ff   <= '0;
            p_ff   <= '0;
            ma_ff  <= 96'(mag49(d_in));
            mb_ff  <= 64'(mag49(d_in));
         end
         E_DSQ: begin
            if (mul_last) begin
               dn_ff  <= acc_sum;
               dd_ff  <= {96'b0, n_ff, 16'b0};
               rem_ff <= '0;
            end
         end
         E_BDIV, E_WDIV, E_RDIV: begin
            rem_ff <= rem_next;
            quo_ff <= quo_next;
            dn_ff  <= {dn_ff[126:0], 1'b0};
            if (cnt_ff == 7'd127) begin
               if (state_ff == E_BDIV) begin
                  b_ff   <= w_new;
                  ma_ff  <= 96'(mag48(s1_ff));
                  mb_ff  <= 64'(mag48(s1_ff));
               end else if (state_ff == E_WDIV) begin
                  w_ff   <= w_new;
                  ma_ff  <= 96'(w_new);
                  mb_ff  <= 64'(n_ff - HALF_W'(1));
               end else begin
                  sq_ff  <= quo_next[63:0];
                  r_ff   <= '0;
                  if (quo_next[127:64] != '0) p_ff <= {POT_W{1'b1}};
               end
            end
         end
         E_TSQ1: begin
            if (mul_last) begin
               ma_ff <= 96'(mag48(s2_ff));
               mb_ff <= 64'(mag48(s2_ff));
            end
         end
         E_TSQ2: begin
            if (mul_last) begin
               tsq_ff <= acc_sum;
               ma_ff  <= 96'({1'b0, q1_ff} + {1'b0, q2_ff});
               mb_ff  <= {32'b0, n_ff, 16'b0};
            end
         end
         E_NUM: begin
            if (mul_last) begin
               dn_ff  <= acc_sum - tsq_ff;
               dd_ff  <= {79'b0, nn1_ff, 17'b0};
               rem_ff <= '0;
            end
         end
         E_RNUM: begin
            if (mul_last) begin
               dn_ff  <= {acc_sum[95:0], 32'b0};
               ma_ff  <= 96'(w_ff);
               mb_ff  <= 64'(n_ff);
            end
         end
         E_RDEN: begin
            if (mul_last) begin
               dd_ff  <= acc_sum;
               rem_ff <= '0;
            end
         end
         E_SQRT: begin
            if (csq <= sq_ff) r_ff <= cand;
            if (cnt_ff[4:0] == 5'd0) p_ff <= (csq <= sq_ff) ? cand : r_ff;
         end
         E_DONE: begin
            p_ff <= p_ff;
         end
         default: begin
            p_ff <= p_ff;
         end
      endcase
   end

   assign eng_res.done = (state_ff == E_DONE);
   assign eng_res.b    = b_ff;
   assign eng_res.w    = w_ff;
   assign eng_res.p    = p_ff;

endmodule

### rtl/core/split_chain_convergence_diagnostic.sv
// ----------------------------------------------------------------------------
// split_chain_convergence_diagnostic
// Two-sequence potential scale reduction over a stream of sample vectors.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-----------------------------
//  request  | start, busy, req_payload       | taken when start & !busy
//  response | rsp_strobe, rsp_payload        | one-cycle strobe, no stall
//  csr      | csr_valid, csr_ready, csr_data | written when valid & ready
//
// A sample element is taken every cycle while busy is low; its sums are
// updated in a read-modify-write on one memory, with forwarding of the
// last write. A query holds busy through at most the three 128-step divides,
// the multiply steps and the 32-step root; a query that cannot give
// statistics skips them. The response strobe comes in the cycle after the
// last busy cycle. After reset busy stays high while the memory is cleared.
// ----------------------------------------------------------------------------
module split_chain_convergence_diagnostic #(
   parameter int VARS = scd_pkg::SCD_VARS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  scd_pkg::req_type             req_payload,
   output logic                         rsp_strobe,
   output scd_pkg::rsp_type             rsp_payload,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [scd_pkg::TOTAL_W-1:0]  csr_data
);
   import scd_pkg::*;

   localparam int DEPTH = 2 * VARS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MW    = VSUM_W + SSUM_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW-1:0] HALF_OFS  = AW'(VARS);

   typedef enum logic [3:0] {
      Q_IDLE  = 4'b0001,
      Q_READ  = 4'b0010,
      Q_START = 4'b0100,
      Q_WAIT  = 4'b1000
   } qst_type;

   logic [MW-1:0]             mem [DEPTH];
   logic [MW-1:0]             rd0_ff, rd1_ff;
   logic [AW-1:0]             rd0_addr, rd1_addr, wr_addr;
   logic [MW-1:0]             wr_data;
   logic                      wr_en;

   logic                      clr_ff;
   logic [AW-1:0]             clr_addr_ff;
   logic [TOTAL_W-1:0]        total_ff, count_ff;
   qst_type                   qst_ff;
   logic [IDX_W-1:0]          qidx_ff;
   logic                      ready_ff;

   logic                      s1v_ff;
   logic [AW-1:0]             s1_addr_ff;
   logic signed [31:0]        s1_x_ff;
   logic                      wb_valid_ff;
   logic [AW-1:0]             wb_addr_ff;
   logic [MW-1:0]             wb_data_ff;

   logic                      rsp_strobe_ff;
   rsp_type                   rsp_ff;

   logic                      accept, acc_sample, acc_query, in_range, half1;
   logic [TOTAL_W-1:0]        n_total;
   logic [AW-1:0]             smp_addr, q_addr;
   logic [MW-1:0]             base;
   logic signed [VSUM_W:0]    vsum;
   logic [VSUM_W-1:0]         vnew;
   logic [31:0]               xmag;
   logic [63:0]               xsq;
   logic [SSUM_W:0]           ssum;
   logic [SSUM_W-1:0]         snew;
   logic                      q_ready, q_in_range;
   eng_req_type               eng_req;
   eng_res_type               eng_res;

   assign busy       = clr_ff || (qst_ff != Q_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = start && !busy;
   assign acc_query  = accept && (req_payload.opcode == OP_QUERY);
   assign n_total    = {1'b0, total_ff[TOTAL_W-1:1]};
   assign in_range   = 32'(req_payload.var_index) < VARS;
   assign half1      = !((TOTAL_W+1)'(count_ff) + (TOTAL_W+1)'(n_total)
                         < (TOTAL_W+1)'(total_ff));
   assign acc_sample = accept && (req_payload.opcode == OP_SAMPLE)
                       && (count_ff < total_ff) && in_range;
   assign smp_addr   = half1 ? HALF_OFS + AW'(req_payload.var_index)
                             : AW'(req_payload.var_index);
   assign q_addr     = AW'(qidx_ff);
   assign rd0_addr   = (qst_ff == Q_READ) ? q_addr : smp_addr;
   assign rd1_addr   = HALF_OFS + q_addr;

   // Stage one of the accumulate: take the freshest copy of the entry.
   always_comb begin
      base = (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) ? wb_data_ff : rd0_ff;
      vsum = {base[MW-1], base[MW-1:SSUM_W]} + (VSUM_W+1)'(s1_x_ff);
      priority if (vsum[VSUM_W] != vsum[VSUM_W-1]) begin
         vnew = vsum[VSUM_W] ? {1'b1, {(VSUM_W-1){1'b0}}} : {1'b0, {(VSUM_W-1){1'b1}}};
      end else begin
         vnew = vsum[VSUM_W-1:0];
      end
      xmag = s1_x_ff[31] ? 32'(-s1_x_ff) : 32'(s1_x_ff);
      xsq  = 64'(xmag) * 64'(xmag);
      ssum = {1'b0, base[SSUM_W-1:0]} + (SSUM_W+1)'(xsq[63:16]);
      snew = ssum[SSUM_W] ? {SSUM_W{1'b1}} : ssum[SSUM_W-1:0];
      wr_en   = clr_ff || s1v_ff;
      wr_addr = clr_ff ? clr_addr_ff : s1_addr_ff;
      wr_data = clr_ff ? '0 : {vnew, snew};
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd0_ff <= mem[rd0_addr];
      rd1_ff <= mem[rd1_addr];
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= smp_addr;
      s1_x_ff    <= req_payload.sample_value;
      wb_addr_ff <= s1_addr_ff;
      wb_data_ff <= wr_data;
      if (acc_query) qidx_ff <= req_payload.var_index;
      if (qst_ff == Q_START) ready_ff <= q_ready;
      if (eng_res.done) begin
         rsp_ff.query_index      <= qidx_ff;
         rsp_ff.ready_res        <= ready_ff;
         rsp_ff.between_variance <= eng_res.b;
         rsp_ff.within_variance  <= eng_res.w;
         rsp_ff.potential        <= eng_res.p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= 1'b1;
         clr_addr_ff   <= '0;
         total_ff      <= TOTAL_RESET;
         count_ff      <= '0;
         qst_ff        <= Q_IDLE;
         s1v_ff        <= 1'b0;
         wb_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) clr_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) total_ff <= csr_data;
         if (accept && (req_payload.opcode == OP_SAMPLE) && req_payload.last_element
             && (count_ff != COUNT_MAX)) begin
            count_ff <= count_ff + TOTAL_W'(1);
         end
         s1v_ff        <= acc_sample;
         wb_valid_ff   <= s1v_ff;
         rsp_strobe_ff <= eng_res.done;
         unique case (qst_ff)
            Q_IDLE:  if (acc_query) qst_ff <= Q_READ;
            Q_READ:  qst_ff <= Q_START;
            Q_START: qst_ff <= Q_WAIT;
            Q_WAIT:  if (eng_res.done) qst_ff <= Q_IDLE;
            default: qst_ff <= Q_IDLE;
         endcase
      end
   end

   assign q_ready    = (count_ff == total_ff);
   assign q_in_range = 32'(qidx_ff) < VARS;

   always_comb begin
      eng_req.start   = (qst_ff == Q_START);
      eng_req.calc_ok = q_ready && q_in_range && (n_total >= TOTAL_W'(2));
      eng_req.s1      = rd0_ff[MW-1:SSUM_W];
      eng_req.s2      = rd1_ff[MW-1:SSUM_W];
      eng_req.q1      = rd0_ff[SSUM_W-1:0];
      eng_req.q2      = rd1_ff[SSUM_W-1:0];
      eng_req.n       = n_total[HALF_W-1:0];
   end

   scd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .eng_req (eng_req),
      .eng_res (eng_res)
   );

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // No accumulate may be in flight while the memory is being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !s1v_ff && !wb_valid_ff)
      else $error("accumulate overlaps clearing pass");

   // The engine only finishes while a query is outstanding.
   a_done_in_query: assert property (@(posedge clock) disable iff (reset)
      eng_res.done |-> qst_ff == Q_WAIT)
      else $error("engine done without a query");

   // A response for a run that is not complete carries no statistics.
   a_not_ready_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.ready_res |->
         rsp_payload.between_variance == '0 && rsp_payload.within_variance == '0
         && rsp_payload.potential == '0)
      else $error("statistics given for an incomplete run");

endmodule
